// ===== src/atst_pkg.sv =====
package atst_pkg;

    // table geometry
    localparam int SLOTS      = 8;
    localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W      = $clog2(SLOTS + 1);

    // alarm times must be whole multiples of this step
    localparam int TIME_STEP = 100;

    // reciprocal of the step: q = (t * STEP_MAGIC) >> (32 + STEP_SHIFT)
    // undershoots the true quotient by at most one, so t - q * step < 2 * step
    localparam int          STEP_SHIFT      = $clog2(TIME_STEP + 1) - 1;
    localparam logic [63:0] STEP_MAGIC_WIDE =
        ((64'd1 << (32 + STEP_SHIFT)) - 64'd1) / 64'(TIME_STEP);
    localparam logic [31:0] STEP_MAGIC      = STEP_MAGIC_WIDE[31:0];
    localparam int          REM_W           = $clog2(2 * TIME_STEP + 1);
    localparam logic [REM_W-1:0] STEP_REM   = REM_W'(TIME_STEP);

    typedef enum logic [1:0] {
        CMD_SET    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_e_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_ZERO         = 3'd1,
        ST_NOT_MULTIPLE = 3'd2,
        ST_DUPLICATE    = 3'd3,
        ST_FULL         = 3'd4
    } status_e_t;

    typedef struct packed {
        cmd_e_t      command;
        logic [31:0] alarm_time;
        logic [15:0] handle;
    } cmd_word_t;

    typedef struct packed {
        status_e_t   status;
        logic        found;
        logic [15:0] found_handle;
        logic [3:0]  alarm_count;
    } rsp_word_t;

    // command word plus the precomputed step check
    typedef struct packed {
        cmd_word_t item;
        logic      step_ok;
    } chk_word_t;

endpackage

// ===== src/atst_step_check.sv =====
module atst_step_check (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  atst_pkg::cmd_word_t cmd_word,
    output logic                chk_valid,
    input  logic                chk_ready,
    output atst_pkg::chk_word_t chk_word
);

    logic                           s1_valid_reg;
    atst_pkg::cmd_word_t            s1_word_reg;
    logic                           s2_valid_reg;
    atst_pkg::cmd_word_t            s2_word_reg;
    logic [31:0]                    quot_reg;
    logic [31:0]                    quot_next;
    logic                           s3_valid_reg;
    atst_pkg::cmd_word_t            s3_word_reg;
    logic                           step_ok_reg;
    logic                           step_ok_next;
    logic [63:0]                    prod;
    logic [atst_pkg::REM_W-1:0]     quot_x_step;
    logic [atst_pkg::REM_W-1:0]     rem;
    logic                           load1;
    logic                           load2;
    logic                           load3;

    // each stage moves when it is empty or the next one takes its word
    assign load3     = !s3_valid_reg || chk_ready;
    assign load2     = !s2_valid_reg || load3;
    assign load1     = !s1_valid_reg || load2;
    assign cmd_ready = load1;

    // quotient estimate from the reciprocal
    always_comb
    begin
        prod      = 64'(s1_word_reg.alarm_time) * 64'(atst_pkg::STEP_MAGIC);
        quot_next = 32'(prod >> (32 + atst_pkg::STEP_SHIFT));
    end

    // remainder is below two steps, so only its low bits matter
    always_comb
    begin
        quot_x_step  = atst_pkg::REM_W'(quot_reg[atst_pkg::REM_W-1:0] * atst_pkg::STEP_REM);
        rem          = s2_word_reg.alarm_time[atst_pkg::REM_W-1:0] - quot_x_step;
        step_ok_next = (rem == '0) || (rem == atst_pkg::STEP_REM);
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (load1)
            begin
                s1_valid_reg <= cmd_valid;
            end
            if (load2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (load3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (load1 && cmd_valid)
        begin
            s1_word_reg <= cmd_word;
        end
        if (load2 && s1_valid_reg)
        begin
            s2_word_reg <= s1_word_reg;
            quot_reg    <= quot_next;
        end
        if (load3 && s2_valid_reg)
        begin
            s3_word_reg <= s2_word_reg;
            step_ok_reg <= step_ok_next;
        end
    end

    assign chk_valid        = s3_valid_reg;
    assign chk_word.item    = s3_word_reg;
    assign chk_word.step_ok = step_ok_reg;

endmodule

// ===== src/atst_slot_table.sv =====
module atst_slot_table (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                chk_valid,
    output logic                chk_ready,
    input  atst_pkg::chk_word_t chk_word,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output atst_pkg::rsp_word_t rsp_word
);

    logic [31:0]                slot_time_reg   [atst_pkg::SLOTS];
    logic [15:0]                slot_handle_reg [atst_pkg::SLOTS];
    logic [31:0]                slot_time_next  [atst_pkg::SLOTS];
    logic [15:0]                slot_handle_next[atst_pkg::SLOTS];
    logic [atst_pkg::CNT_W-1:0] count_reg;
    logic [atst_pkg::CNT_W-1:0] count_next;
    logic                       rsp_valid_reg;
    atst_pkg::rsp_word_t        rsp_word_reg;
    atst_pkg::rsp_word_t        rsp_word_next;
    logic [atst_pkg::SLOTS-1:0] hit_vec;
    logic [atst_pkg::SLOTS-1:0] free_vec;
    logic [atst_pkg::SLOTS-1:0] free_first;
    logic [15:0]                hit_handle;
    logic                       hit_any;
    logic                       time_zero;
    logic                       set_ok;
    logic                       fire;

    assign chk_ready = !rsp_valid_reg || rsp_ready;
    assign fire      = chk_valid && chk_ready;
    assign time_zero = (chk_word.item.alarm_time == 32'd0);

    // parallel match and free detect over all slots
    always_comb
    begin
        hit_handle = '0;
        for (int i = 0; i < atst_pkg::SLOTS; i++)
        begin
            hit_vec[i]  = !time_zero && (slot_time_reg[i] == chk_word.item.alarm_time);
            free_vec[i] = (slot_time_reg[i] == 32'd0);
            hit_handle  = hit_handle | (slot_handle_reg[i] & {16{hit_vec[i]}});
        end
        hit_any    = |hit_vec;
        // lowest free slot
        free_first = free_vec & (~free_vec + atst_pkg::SLOTS'(1));
    end

    // command decode, table update and result word
    always_comb
    begin
        set_ok                     = 1'b0;
        count_next                 = count_reg;
        rsp_word_next.status       = atst_pkg::ST_OK;
        rsp_word_next.found        = hit_any;
        rsp_word_next.found_handle = '0;
        unique case (chk_word.item.command)
            atst_pkg::CMD_SET:
            begin
                priority if (time_zero)
                begin
                    rsp_word_next.status = atst_pkg::ST_ZERO;
                end
                else if (!chk_word.step_ok)
                begin
                    rsp_word_next.status = atst_pkg::ST_NOT_MULTIPLE;
                end
                else if (hit_any)
                begin
                    rsp_word_next.status = atst_pkg::ST_DUPLICATE;
                end
                else if (free_vec == '0)
                begin
                    rsp_word_next.status = atst_pkg::ST_FULL;
                end
                else
                begin
                    set_ok     = 1'b1;
                    count_next = count_reg + atst_pkg::CNT_W'(1);
                end
            end
            atst_pkg::CMD_REMOVE:
            begin
                if (hit_any)
                begin
                    count_next = count_reg - atst_pkg::CNT_W'(1);
                end
            end
            atst_pkg::CMD_LOOKUP:
            begin
                rsp_word_next.found_handle = hit_handle;
            end
            atst_pkg::CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        rsp_word_next.alarm_count = 4'(count_next);

        for (int i = 0; i < atst_pkg::SLOTS; i++)
        begin
            slot_time_next[i]   = slot_time_reg[i];
            slot_handle_next[i] = slot_handle_reg[i];
            if (chk_word.item.command == atst_pkg::CMD_CLEAR)
            begin
                slot_time_next[i]   = '0;
                slot_handle_next[i] = '0;
            end
            else if (set_ok && free_first[i])
            begin
                slot_time_next[i]   = chk_word.item.alarm_time;
                slot_handle_next[i] = chk_word.item.handle;
            end
            else if (chk_word.item.command == atst_pkg::CMD_REMOVE && hit_vec[i])
            begin
                slot_time_next[i]   = '0;
                slot_handle_next[i] = '0;
            end
        end
    end

    // table state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < atst_pkg::SLOTS; i++)
            begin
                slot_time_reg[i]   <= '0;
                slot_handle_reg[i] <= '0;
            end
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                for (int i = 0; i < atst_pkg::SLOTS; i++)
                begin
                    slot_time_reg[i]   <= slot_time_next[i];
                    slot_handle_reg[i] <= slot_handle_next[i];
                end
                count_reg <= count_next;
            end
            if (chk_ready)
            begin
                rsp_valid_reg <= chk_valid;
            end
        end
    end

    // result word register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_word_reg <= rsp_word_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule

// ===== src/alarm_time_slot_table_top.sv =====
// channel   signals                          direction  accepted when
// cmd       cmd_valid cmd_ready cmd_word     in         cmd_valid && cmd_ready
// rsp       rsp_valid rsp_ready rsp_word     out        rsp_valid && rsp_ready
//
// one word in, one word out; a new word can enter every cycle while the rsp side is not stalled
// the result is registered in the step-multiple check stages (capture, reciprocal
// multiply, remainder) and then in the result register of the slot table
// reset empties the table; the first word can be taken right after reset
// a stalled rsp side fills the stages, then cmd_ready drops
module alarm_time_slot_table_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  atst_pkg::cmd_word_t cmd_word,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output atst_pkg::rsp_word_t rsp_word
);

    logic                chk_valid;
    logic                chk_ready;
    atst_pkg::chk_word_t chk_word;

    // step-multiple check ahead of the table
    atst_step_check u_step_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_word  (cmd_word),
        .chk_valid (chk_valid),
        .chk_ready (chk_ready),
        .chk_word  (chk_word)
    );

    // slot table and result register
    atst_slot_table u_slot_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .chk_valid (chk_valid),
        .chk_ready (chk_ready),
        .chk_word  (chk_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word)
    );

endmodule

// ===== src/atst_checker.sv =====
module atst_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input atst_pkg::rsp_word_t rsp_word
);

    // a stalled result word stays up
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp word dropped while stalled");

    // a stalled result word does not change
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_word))
        else $error("rsp word changed while stalled");

    // the count never exceeds the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (atst_pkg::SLOTS > 15) || (rsp_word.alarm_count <= 4'(atst_pkg::SLOTS)))
        else $error("alarm count above slot count");

    // a returned handle comes only from a matching slot
    a_handle_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_word.found_handle != 16'd0) |-> rsp_word.found)
        else $error("handle returned without a match");

    // duplicate needs a match, zero time never matches
    a_status_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp_word.status != atst_pkg::ST_DUPLICATE) || rsp_word.found)
                   && ((rsp_word.status != atst_pkg::ST_ZERO) || !rsp_word.found))
        else $error("status disagrees with found");

endmodule

bind alarm_time_slot_table_top atst_checker u_atst_checker (.*);
